// File: rtl/lcs_pkg.sv
package lcs_pkg;

  localparam int HIDDEN_DEF    = 16;
  localparam int INPUTS_DEF    = 8;
  localparam int ACT_DEPTH_DEF = 256;
  localparam int CFG_W         = 5;

  localparam logic [2:0] MODE_W_IN   = 3'd0;
  localparam logic [2:0] MODE_W_REC  = 3'd1;
  localparam logic [2:0] MODE_BIAS   = 3'd2;
  localparam logic [2:0] MODE_SAMPLE = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  localparam logic CFG_HIDDEN_USED = 1'b0;
  localparam logic CFG_INPUTS_USED = 1'b1;

  localparam logic [4:0] HIDDEN_USED_RST = 5'd16;
  localparam logic [3:0] INPUTS_USED_RST = 4'd8;

  localparam logic [1:0] GATE_FORGET = 2'd0;
  localparam logic [1:0] GATE_INPUT  = 2'd1;
  localparam logic [1:0] GATE_CAND   = 2'd2;
  localparam logic [1:0] GATE_OUTPUT = 2'd3;

  localparam logic signed [15:0] Q_ONE = 16'sd4096;
  localparam int Q_MAX = 32767;
  localparam int Q_MIN = -32768;
  localparam longint Q31_ONE = 64'sd2147483648;

  typedef enum logic [2:0] {
    TERM_BIAS,
    TERM_WX,
    TERM_UH,
    TERM_FC,
    TERM_IG,
    TERM_OT
  } term_e;

  typedef enum logic [1:0] {
    DEST_GATE,
    DEST_CELL,
    DEST_HID
  } dest_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GATE,
    ST_GWAIT,
    ST_CELL_FC,
    ST_CELL_IG,
    ST_CWAIT,
    ST_HID,
    ST_HWAIT,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  typedef struct packed {
    logic       load;
    logic       clr;
    logic       issue;
    term_e      term;
    logic       first;
    logic       last;
    dest_e      dest;
    logic [1:0] gate;
    logic       emit_ld;
    logic       emit_final;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_vld;
  } dp_sts_t;

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dv);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= dv) begin
        r    = r - dv;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // table entry at the bin midpoint, e^-|x| from a series on |x|/16 squared four times
  function automatic logic signed [15:0] act_entry(input int j, input int depth,
                                                   input logic is_tanh);
    longint      dd;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] g;
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] p2;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    longint      sum;
    dd  = 2 * longint'(j) + 1 - longint'(depth);
    neg = dd < 0;
    mag = neg ? 64'(-dd) : 64'(dd);
    g   = udiv64(mag << 30, 64'(depth));
    sum = Q31_ONE;
    t   = 64'(Q31_ONE);
    for (int k = 1; k <= 16; k++) begin
      t = udiv64((t * g) >> 31, 64'(k));
      if ((k & 1) != 0) sum = sum - longint'(t);
      else sum = sum + longint'(t);
    end
    p = 64'(sum);
    for (int s = 0; s < 4; s++) p = (p * p) >> 31;
    p2 = (p * p) >> 31;
    if (is_tanh) begin
      den = 64'(Q31_ONE) + p2;
      q   = udiv64((64'(Q31_ONE) - p2) * 64'd8192 + den, den << 1);
      return neg ? -16'(q) : 16'(q);
    end
    den = 64'(Q31_ONE) + p;
    num = neg ? p : 64'(Q31_ONE);
    q   = udiv64(num * 64'd8192 + den, den << 1);
    return 16'(q);
  endfunction

endpackage

// File: rtl/lstm_cell_step_core.sv
// LSTM cell, one layer, Q4.12 fixed point.
// Input channel (in_valid_i/in_ready_o): each beat is a weight, recurrent weight or
// bias load, a sample element, or a clear of the hidden and cell state. Loads, clears
// and non-final samples are taken without leaving the idle state.
// A sample beat with last_i set (and a nonzero hidden count) runs one time step on a
// single shared MAC unit; the input stays stalled until the step is done and every
// result beat has been loaded into the output register.
// Output channel (out_valid_o/out_ready_i): one beat per hidden unit in use from a single
// output register; final_res_o marks the last.
// A stalled receiver holds the register and stops further beats, nothing is lost.
// Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) is to be written by the user only while
// the block is idle; the block itself does not enforce this. After reset a clearing pass
// zeroes the weight and bias memories with in_ready_o low; hidden and cell state read as
// zero until the first step writes them.
module lstm_cell_step_core #(
  parameter int HIDDEN          = lcs_pkg::HIDDEN_DEF,
  parameter int INPUTS          = lcs_pkg::INPUTS_DEF,
  parameter int ACT_TABLE_DEPTH = lcs_pkg::ACT_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                mode_i,
  input  logic [1:0]                gate_i,
  input  logic [3:0]                row_i,
  input  logic [3:0]                col_i,
  input  logic signed [15:0]        value_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [3:0]                unit_o,
  output logic signed [15:0]        hidden_value_o,
  output logic signed [15:0]        cell_value_o,
  output logic                      final_res_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [lcs_pkg::CFG_W-1:0] cfg_data_i
);
  import lcs_pkg::*;

  localparam int MX   = (HIDDEN > INPUTS) ? HIDDEN : INPUTS;
  localparam int RW   = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
  localparam int CW   = (MX > 1) ? $clog2(MX) : 1;
  localparam int CLRW = $clog2(4 * HIDDEN * MX);

  dp_cmd_t         cmd;
  dp_sts_t         sts;
  logic [RW-1:0]   seq_row;
  logic [CW-1:0]   seq_col;
  logic [CLRW-1:0] clr_addr;

  lcs_ctrl #(
    .HIDDEN (HIDDEN),
    .INPUTS (INPUTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .last_i     (last_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_o      (cmd),
    .sts_i      (sts),
    .row_o      (seq_row),
    .col_o      (seq_col),
    .clr_addr_o (clr_addr)
  );

  lcs_datapath #(
    .HIDDEN          (HIDDEN),
    .INPUTS          (INPUTS),
    .ACT_TABLE_DEPTH (ACT_TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .seq_row_i      (seq_row),
    .seq_col_i      (seq_col),
    .clr_addr_i     (clr_addr),
    .mode_i         (mode_i),
    .gate_i         (gate_i),
    .ld_row_i       (row_i),
    .ld_col_i       (col_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .unit_o         (unit_o),
    .hidden_value_o (hidden_value_o),
    .cell_value_o   (cell_value_o),
    .final_res_o    (final_res_o)
  );

endmodule

// File: rtl/lcs_ctrl.sv
module lcs_ctrl #(
  parameter int HIDDEN = lcs_pkg::HIDDEN_DEF,
  parameter int INPUTS = lcs_pkg::INPUTS_DEF,
  localparam int MX   = (HIDDEN > INPUTS) ? HIDDEN : INPUTS,
  localparam int RW   = (HIDDEN > 1) ? $clog2(HIDDEN) : 1,
  localparam int CW   = (MX > 1) ? $clog2(MX) : 1,
  localparam int CLRW = $clog2(4 * HIDDEN * MX)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 mode_i,
  input  logic                       last_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [lcs_pkg::CFG_W-1:0]  cfg_data_i,
  output lcs_pkg::dp_cmd_t           cmd_o,
  input  lcs_pkg::dp_sts_t           sts_i,
  output logic [RW-1:0]              row_o,
  output logic [CW-1:0]              col_o,
  output logic [CLRW-1:0]            clr_addr_o
);
  import lcs_pkg::*;

  localparam int CLR_N = 4 * HIDDEN * MX;
  localparam int NW    = $clog2(HIDDEN + 1);
  localparam int MW    = $clog2(INPUTS + 1);

  state_e          state_q, state_d;
  logic [RW-1:0]   row_q, row_d;
  logic [CW-1:0]   col_q, col_d;
  logic [1:0]      gate_q, gate_d;
  term_e           term_q, term_d;
  logic [CLRW-1:0] clr_q, clr_d;
  logic [4:0]      hid_used_q;
  logic [3:0]      in_used_q;
  logic [NW-1:0]   n_w;
  logic [MW-1:0]   m_w;
  logic            col_end_m, col_end_n, row_end;

  assign n_w = (32'(hid_used_q) < HIDDEN) ? NW'(hid_used_q) : NW'(HIDDEN);
  assign m_w = (32'(in_used_q) < INPUTS) ? MW'(in_used_q) : MW'(INPUTS);
  assign col_end_m = (32'(col_q) + 1) == 32'(m_w);
  assign col_end_n = (32'(col_q) + 1) == 32'(n_w);
  assign row_end   = (32'(row_q) + 1) == 32'(n_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hid_used_q <= HIDDEN_USED_RST;
      in_used_q  <= INPUTS_USED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HIDDEN_USED: hid_used_q <= cfg_data_i[4:0];
        CFG_INPUTS_USED: in_used_q  <= cfg_data_i[3:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      row_q   <= '0;
      col_q   <= '0;
      gate_q  <= '0;
      term_q  <= TERM_BIAS;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      gate_q  <= gate_d;
      term_q  <= term_d;
      clr_q   <= clr_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    gate_d     = gate_q;
    term_d     = term_q;
    clr_d      = clr_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.term = term_q;
    cmd_o.gate = gate_q;
    cmd_o.dest = DEST_GATE;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == CLR_N - 1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (mode_i == MODE_SAMPLE && last_i && n_w != '0) begin
            state_d = ST_GATE;
            row_d   = '0;
            col_d   = '0;
            gate_d  = '0;
            term_d  = TERM_BIAS;
          end
        end
      end
      ST_GATE: begin
        cmd_o.issue = 1'b1;
        unique case (term_q)
          TERM_BIAS: begin
            cmd_o.first = 1'b1;
            col_d  = '0;
            term_d = (m_w != '0) ? TERM_WX : TERM_UH;
          end
          TERM_WX: begin
            if (col_end_m) begin
              col_d  = '0;
              term_d = TERM_UH;
            end else begin
              col_d = col_q + 1'b1;
            end
          end
          TERM_UH: begin
            if (col_end_n) begin
              cmd_o.last = 1'b1;
              col_d  = '0;
              term_d = TERM_BIAS;
              gate_d = gate_q + 1'b1;
              if (gate_q == GATE_OUTPUT) state_d = ST_GWAIT;
            end else begin
              col_d = col_q + 1'b1;
            end
          end
          default: term_d = TERM_BIAS;
        endcase
      end
      ST_GWAIT: begin
        if (!sts_i.busy) state_d = ST_CELL_FC;
      end
      ST_CELL_FC: begin
        cmd_o.issue = 1'b1;
        cmd_o.term  = TERM_FC;
        cmd_o.first = 1'b1;
        cmd_o.dest  = DEST_CELL;
        state_d = ST_CELL_IG;
      end
      ST_CELL_IG: begin
        cmd_o.issue = 1'b1;
        cmd_o.term  = TERM_IG;
        cmd_o.last  = 1'b1;
        cmd_o.dest  = DEST_CELL;
        state_d = ST_CWAIT;
      end
      ST_CWAIT: begin
        if (!sts_i.busy) state_d = ST_HID;
      end
      ST_HID: begin
        cmd_o.issue = 1'b1;
        cmd_o.term  = TERM_OT;
        cmd_o.first = 1'b1;
        cmd_o.last  = 1'b1;
        cmd_o.dest  = DEST_HID;
        state_d = ST_HWAIT;
      end
      ST_HWAIT: begin
        if (!sts_i.busy) begin
          if (row_end) begin
            row_d   = '0;
            state_d = ST_EMIT_RD;
          end else begin
            row_d   = row_q + 1'b1;
            state_d = ST_GATE;
          end
        end
      end
      ST_EMIT_RD: begin
        if (!sts_i.out_vld) state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd_o.emit_ld    = 1'b1;
        cmd_o.emit_final = row_end;
        if (row_end) begin
          row_d   = '0;
          state_d = ST_IDLE;
        end else begin
          row_d   = row_q + 1'b1;
          state_d = ST_EMIT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign row_o      = row_q;
  assign col_o      = col_q;
  assign clr_addr_o = clr_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.emit_ld |-> !sts_i.out_vld)
    else $error("result loaded over a pending beat");
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> !sts_i.busy)
    else $error("input taken while the MAC pipeline is busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CWAIT && sts_i.busy) |=> state_q == ST_CWAIT)
    else $error("cell wait left before the pipeline drained");

endmodule

// File: rtl/lcs_datapath.sv
module lcs_datapath #(
  parameter int HIDDEN          = lcs_pkg::HIDDEN_DEF,
  parameter int INPUTS          = lcs_pkg::INPUTS_DEF,
  parameter int ACT_TABLE_DEPTH = lcs_pkg::ACT_DEPTH_DEF,
  localparam int MX   = (HIDDEN > INPUTS) ? HIDDEN : INPUTS,
  localparam int RW   = (HIDDEN > 1) ? $clog2(HIDDEN) : 1,
  localparam int CW   = (MX > 1) ? $clog2(MX) : 1,
  localparam int CLRW = $clog2(4 * HIDDEN * MX)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcs_pkg::dp_cmd_t   cmd_i,
  output lcs_pkg::dp_sts_t   sts_o,
  input  logic [RW-1:0]      seq_row_i,
  input  logic [CW-1:0]      seq_col_i,
  input  logic [CLRW-1:0]    clr_addr_i,
  input  logic [2:0]         mode_i,
  input  logic [1:0]         gate_i,
  input  logic [3:0]         ld_row_i,
  input  logic [3:0]         ld_col_i,
  input  logic signed [15:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         unit_o,
  output logic signed [15:0] hidden_value_o,
  output logic signed [15:0] cell_value_o,
  output logic               final_res_o
);
  import lcs_pkg::*;

  localparam int WI_N  = 4 * HIDDEN * INPUTS;
  localparam int WR_N  = 4 * HIDDEN * HIDDEN;
  localparam int B_N   = 4 * HIDDEN;
  localparam int WI_AW = $clog2(WI_N);
  localparam int WR_AW = $clog2(WR_N);
  localparam int B_AW  = $clog2(B_N);
  localparam int XW    = (INPUTS > 1) ? $clog2(INPUTS) : 1;
  localparam int TW    = $clog2(ACT_TABLE_DEPTH);
  localparam int ACC_W = 33 + $clog2(INPUTS + HIDDEN + 1);

  logic signed [15:0] wi_mem [WI_N];
  logic signed [15:0] wr_mem [WR_N];
  logic signed [15:0] b_mem  [B_N];
  logic signed [15:0] x_mem  [INPUTS];
  logic signed [15:0] h_mem  [HIDDEN];
  logic signed [15:0] c_mem  [HIDDEN];
  logic signed [15:0] nh_mem [HIDDEN];
  logic signed [15:0] nc_mem [HIDDEN];
  logic [HIDDEN-1:0]  st_vld_q;

  logic signed [15:0] sig_tab  [ACT_TABLE_DEPTH];
  logic signed [15:0] tanh_tab [ACT_TABLE_DEPTH];

  for (genvar j = 0; j < ACT_TABLE_DEPTH; j++) begin : g_tab
    localparam logic signed [15:0] SIG_V  = act_entry(j, ACT_TABLE_DEPTH, 1'b0);
    localparam logic signed [15:0] TANH_V = act_entry(j, ACT_TABLE_DEPTH, 1'b1);
    assign sig_tab[j]  = SIG_V;
    assign tanh_tab[j] = TANH_V;
  end

  // load decode
  logic               ld_row_ok, ld_cin_ok, ld_crec_ok;
  logic               wi_we, wr_we, b_we, x_we;
  logic [WI_AW-1:0]   wi_wa, wi_ra;
  logic [WR_AW-1:0]   wr_wa, wr_ra;
  logic [B_AW-1:0]    b_wa, b_ra;
  logic signed [15:0] wd;

  assign ld_row_ok  = 32'(ld_row_i) < HIDDEN;
  assign ld_cin_ok  = 32'(ld_col_i) < INPUTS;
  assign ld_crec_ok = 32'(ld_col_i) < HIDDEN;
  assign wd = cmd_i.clr ? 16'sd0 : value_i;

  assign wi_we = (cmd_i.clr && 32'(clr_addr_i) < WI_N) ||
                 (cmd_i.load && mode_i == MODE_W_IN && ld_row_ok && ld_cin_ok);
  assign wr_we = (cmd_i.clr && 32'(clr_addr_i) < WR_N) ||
                 (cmd_i.load && mode_i == MODE_W_REC && ld_row_ok && ld_crec_ok);
  assign b_we  = (cmd_i.clr && 32'(clr_addr_i) < B_N) ||
                 (cmd_i.load && mode_i == MODE_BIAS && ld_row_ok);
  assign x_we  = cmd_i.load && mode_i == MODE_SAMPLE && ld_cin_ok;

  assign wi_wa = cmd_i.clr ? WI_AW'(clr_addr_i) :
                 WI_AW'((int'(gate_i) * HIDDEN + int'(ld_row_i)) * INPUTS + int'(ld_col_i));
  assign wr_wa = cmd_i.clr ? WR_AW'(clr_addr_i) :
                 WR_AW'((int'(gate_i) * HIDDEN + int'(ld_row_i)) * HIDDEN + int'(ld_col_i));
  assign b_wa  = cmd_i.clr ? B_AW'(clr_addr_i) : B_AW'(int'(gate_i) * HIDDEN + int'(ld_row_i));

  assign wi_ra = WI_AW'((int'(cmd_i.gate) * HIDDEN + int'(seq_row_i)) * INPUTS + int'(seq_col_i));
  assign wr_ra = WR_AW'((int'(cmd_i.gate) * HIDDEN + int'(seq_row_i)) * HIDDEN + int'(seq_col_i));
  assign b_ra  = B_AW'(int'(cmd_i.gate) * HIDDEN + int'(seq_row_i));

  logic signed [15:0] wi_rd_q, wr_rd_q, b_rd_q, x_rd_q, h_raw_q, c_raw_q, nh_rd_q, nc_rd_q;
  logic               h_ok_q, c_ok_q;

  // pipeline tags
  logic               s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  term_e              s1_term_q;
  logic               s1_first_q, s1_last_q, s2_first_q, s2_last_q;
  dest_e              s1_dest_q, s2_dest_q, s3_dest_q, s4_dest_q;
  logic [1:0]         s1_gate_q, s2_gate_q, s3_gate_q, s4_gate_q;
  logic [RW-1:0]      s1_row_q, s2_row_q, s3_row_q, s4_row_q;
  logic signed [31:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [15:0] q_q, q_d;
  logic signed [15:0] act_q [4];
  logic signed [15:0] tq_q;
  logic signed [15:0] op_a, op_b, h_op, c_op;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-13:0] shq;
  logic [31:0]        tprod;
  logic [TW-1:0]      t_idx;
  logic signed [15:0] sig_v, tanh_v;
  logic               out_vld_q;

  always_ff @(posedge clk_i) begin
    if (wi_we) wi_mem[wi_wa] <= wd;
    wi_rd_q <= wi_mem[wi_ra];
  end

  always_ff @(posedge clk_i) begin
    if (wr_we) wr_mem[wr_wa] <= wd;
    wr_rd_q <= wr_mem[wr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) b_mem[b_wa] <= wd;
    b_rd_q <= b_mem[b_ra];
  end

  always_ff @(posedge clk_i) begin
    if (x_we) x_mem[XW'(ld_col_i)] <= value_i;
    x_rd_q <= x_mem[XW'(seq_col_i)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ld) begin
      h_mem[seq_row_i] <= nh_rd_q;
      c_mem[seq_row_i] <= nc_rd_q;
    end
    h_raw_q <= h_mem[RW'(seq_col_i)];
    c_raw_q <= c_mem[seq_row_i];
  end

  always_ff @(posedge clk_i) begin
    if (s4_v_q && s4_dest_q == DEST_HID)  nh_mem[s4_row_q] <= q_q;
    if (s4_v_q && s4_dest_q == DEST_CELL) nc_mem[s4_row_q] <= q_q;
    nh_rd_q <= nh_mem[seq_row_i];
    nc_rd_q <= nc_mem[seq_row_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= '0;
      h_ok_q   <= 1'b0;
      c_ok_q   <= 1'b0;
    end else begin
      if (cmd_i.load && mode_i == MODE_CLEAR) st_vld_q <= '0;
      else if (cmd_i.emit_ld) st_vld_q[seq_row_i] <= 1'b1;
      h_ok_q <= st_vld_q[RW'(seq_col_i)];
      c_ok_q <= st_vld_q[seq_row_i];
    end
  end

  assign h_op = h_ok_q ? h_raw_q : 16'sd0;
  assign c_op = c_ok_q ? c_raw_q : 16'sd0;

  always_comb begin
    case (s1_term_q)
      TERM_BIAS: begin op_a = b_rd_q;   op_b = Q_ONE;    end
      TERM_WX:   begin op_a = wi_rd_q;  op_b = x_rd_q;   end
      TERM_UH:   begin op_a = wr_rd_q;  op_b = h_op;     end
      TERM_FC:   begin op_a = act_q[0]; op_b = c_op;     end
      TERM_IG:   begin op_a = act_q[1]; op_b = act_q[2]; end
      TERM_OT:   begin op_a = act_q[3]; op_b = tq_q;     end
      default:   begin op_a = '0;       op_b = '0;       end
    endcase
  end

  // round half up to Q4.12, then saturate
  always_comb begin
    rnd = acc_q + ACC_W'(2048);
    shq = rnd[ACC_W-1:12];
    if (shq > Q_MAX) q_d = 16'sh7fff;
    else if (shq < Q_MIN) q_d = 16'sh8000;
    else q_d = shq[15:0];
  end

  assign tprod  = 32'({~q_q[15], q_q[14:0]}) * 32'(ACT_TABLE_DEPTH);
  assign t_idx  = tprod[16 +: TW];
  assign sig_v  = sig_tab[t_idx];
  assign tanh_v = tanh_tab[t_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q && s2_last_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_term_q  <= cmd_i.term;
    s1_first_q <= cmd_i.first;
    s1_last_q  <= cmd_i.last;
    s1_dest_q  <= cmd_i.dest;
    s1_gate_q  <= cmd_i.gate;
    s1_row_q   <= seq_row_i;
    prod_q     <= op_a * op_b;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_dest_q  <= s1_dest_q;
    s2_gate_q  <= s1_gate_q;
    s2_row_q   <= s1_row_q;
    if (s2_v_q) acc_q <= s2_first_q ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    s3_dest_q  <= s2_dest_q;
    s3_gate_q  <= s2_gate_q;
    s3_row_q   <= s2_row_q;
    q_q        <= q_d;
    s4_dest_q  <= s3_dest_q;
    s4_gate_q  <= s3_gate_q;
    s4_row_q   <= s3_row_q;
    if (s4_v_q) begin
      case (s4_dest_q)
        DEST_GATE: act_q[s4_gate_q] <= (s4_gate_q == GATE_CAND) ? tanh_v : sig_v;
        DEST_CELL: tq_q <= tanh_v;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit_ld) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ld) begin
      unit_o         <= 4'(seq_row_i);
      hidden_value_o <= nh_rd_q;
      cell_value_o   <= nc_rd_q;
      final_res_o    <= cmd_i.emit_final;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign sts_o.busy    = s1_v_q | s2_v_q | s3_v_q | s4_v_q;
  assign sts_o.out_vld = out_vld_q;

endmodule
